FILE: rtl/owdm_pkg.sv
// ----------------------------------------------------------------------------
// owdm_pkg
// Shared types and constants of the omni wheel duty mixer: angle constants,
// the quarter-wave sine table, divider geometry and inter-stage beat types.
// ----------------------------------------------------------------------------
`default_nettype none

package owdm_pkg;

	// field and register widths
	localparam int HEADING_W  = 16;
	localparam int GAIN_W     = 17;
	localparam int N_WHEELS   = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPEED_GAIN   = 2'd0,
		REG_REVERSE_MASK = 2'd1
	} reg_idx_t;

	localparam logic [GAIN_W-1:0]   GAIN_RESET = 17'd13107;
	localparam logic [N_WHEELS-1:0] REV_RESET  = 4'd4;

	// angle arithmetic
	localparam int U_W         = 17;            // 450 - heading, offset to stay positive
	localparam int HEADING_OFS = 450 + 360 * 90;
	localparam int DEG_FULL    = 360;
	localparam int DEG_HALF    = 180;
	localparam int DEG_3Q      = 270;
	localparam int DEG_QUARTER = 90;
	localparam int MOUNT_OFS   = 45;
	localparam int RECIP_360   = 93207;         // ceil(2^25 / 360)
	localparam int RECIP_W     = 17;
	localparam int RECIP_SHIFT = 25;
	localparam int QT_W        = 8;             // quotient of u / 360, at most 182
	localparam int ANGLE_W     = 9;
	localparam int R_W         = 7;

	// sine table, round(sin(k deg) * 32768), k = 0..90
	localparam int SINE_W = 16;
	localparam logic [SINE_W-1:0] SINE_Q15 [DEG_QUARTER+1] = '{
		16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
		16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
		16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
		16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
		16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
		16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
		16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
		16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
		16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
		16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
		16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
		16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
		16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
	};

	// normalizing divider
	localparam int ONE_Q15_SHIFT = 15;
	localparam int NUM_W         = 31;
	localparam int DEN_W         = 16;
	localparam int QUO_W         = 16;
	localparam int DIV_STEP_BITS = 2;
	localparam int DIV_STAGES    = QUO_W / DIV_STEP_BITS;

	// scaling
	localparam int GSQ_W = 2 * GAIN_W;
	localparam int P_W   = 49;

	// per-wheel routing: big selects the larger magnitude (normalized to one)
	typedef struct packed {
		logic [N_WHEELS-1:0] big;
		logic [N_WHEELS-1:0] neg;
	} side_t;

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
		side_t            side;
	} div_in_t;

	typedef struct packed {
		logic [QUO_W-1:0] quot;
		side_t            side;
	} div_out_t;

endpackage

`default_nettype wire

FILE: rtl/owdm_if.sv
// ----------------------------------------------------------------------------
// owdm interfaces
// Valid/ready channels of the mixer: heading commands, wheel duties and
// configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface owdm_cmd_if;
	import owdm_pkg::*;
	logic                        valid;
	logic                        ready;
	logic signed [HEADING_W-1:0] heading;
	modport source (output valid, output heading, input ready);
	modport sink   (input valid, input heading, output ready);
endinterface

interface owdm_duty_if #(
	parameter int unsigned DUTY_BITS = 16
);
	logic                 valid;
	logic                 ready;
	logic [DUTY_BITS-1:0] duty_wheel0;
	logic [DUTY_BITS-1:0] duty_wheel1;
	logic [DUTY_BITS-1:0] duty_wheel2;
	logic [DUTY_BITS-1:0] duty_wheel3;
	modport source (output valid, output duty_wheel0, output duty_wheel1,
		output duty_wheel2, output duty_wheel3, input ready);
	modport sink   (input valid, input duty_wheel0, input duty_wheel1,
		input duty_wheel2, input duty_wheel3, output ready);
endinterface

interface owdm_cfg_if;
	import owdm_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/omni_wheel_duty_mixer.sv
// Throughput: one heading per cycle without output stalls; every stage moves
// whenever the one ahead of it is empty or moving, so bubbles close up under a stall.
// Pipeline: 4 angle/lookup stages, 8 divider stages (2 quotient bits each),
// a gain multiply stage and the duty output register.
// Reset clears all valid bits; speed_gain resets to 13107, reverse_mask to 4.
// ----------------------------------------------------------------------------
// omni_wheel_duty_mixer
// Four-wheel omni drive mixer: heading in degrees to four normalized,
// speed-scaled PWM duties, with a configuration write port.
// ----------------------------------------------------------------------------
`default_nettype none

module omni_wheel_duty_mixer #(
	parameter int unsigned DUTY_BITS = 16
) (
	input  wire          clk,
	input  wire          arst_n,
	owdm_cmd_if.sink     cmd,
	owdm_duty_if.source  duty,
	owdm_cfg_if.sink     cfg
);
	import owdm_pkg::*;

	logic [GAIN_W-1:0]   gain_q;
	logic [N_WHEELS-1:0] rev_q;
	logic [GSQ_W-1:0]    gain_sq_q;

	logic     fr_valid, fr_ready;
	div_in_t  fr_data;
	logic     dv_valid, dv_ready;
	div_out_t dv_data;
	logic [N_WHEELS-1:0][DUTY_BITS-1:0] duty_w;

	// configuration writes, unknown indexes dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
			rev_q  <= REV_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SPEED_GAIN:   gain_q <= cfg.data[GAIN_W-1:0];
				REG_REVERSE_MASK: rev_q  <= cfg.data[N_WHEELS-1:0];
				default: ;
			endcase
		end
	end

	// gain applied twice, squared once ahead of the pipeline
	always_ff @(posedge clk) begin
		gain_sq_q <= GSQ_W'(gain_q) * GSQ_W'(gain_q);
	end

	owdm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.heading   (cmd.heading),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.out_data  (fr_data)
	);

	owdm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_data   (fr_data),
		.out_valid (dv_valid),
		.out_ready (dv_ready),
		.out_data  (dv_data)
	);

	owdm_scale #(
		.DUTY_BITS (DUTY_BITS)
	) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dv_valid),
		.in_ready  (dv_ready),
		.in_data   (dv_data),
		.gain_sq   (gain_sq_q),
		.rev       (rev_q),
		.out_valid (duty.valid),
		.out_ready (duty.ready),
		.duty      (duty_w)
	);

	assign duty.duty_wheel0 = duty_w[0];
	assign duty.duty_wheel1 = duty_w[1];
	assign duty.duty_wheel2 = duty_w[2];
	assign duty.duty_wheel3 = duty_w[3];

endmodule

`default_nettype wire

FILE: rtl/owdm_front.sv
// ----------------------------------------------------------------------------
// owdm_front
// Heading to wheel angles: offset, reduction modulo 360 by reciprocal
// multiply, quadrant split, sine lookups and divider operand setup.
// ----------------------------------------------------------------------------
`default_nettype none

module owdm_front (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  wire signed [owdm_pkg::HEADING_W-1:0]  heading,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output owdm_pkg::div_in_t                     out_data
);
	import owdm_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;

	logic [U_W-1:0]     u_s1, u_s2;
	logic [QT_W-1:0]    qt_s2;
	logic [1:0]         quad_s3;
	logic [R_W-1:0]     r_s3;
	div_in_t            data_s4;

	logic [U_W-1:0]                u_nx;
	logic [U_W+RECIP_W-1:0]        prod;
	logic [U_W-1:0]                rem;
	logic [ANGLE_W-1:0]            a, x0;
	logic [1:0]                    quad_nx;
	logic [ANGLE_W-1:0]            base;
	logic [SINE_W-1:0]             s_r, s_c, m, lesser;
	logic                          cos_big;
	logic [1:0]                    qi;
	div_in_t                       data_nx;

	// stall chain, a bubble lets the stage ahead of it move
	assign adv4     = !v_s4 || out_ready;
	assign adv3     = !v_s3 || adv4;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;
	assign out_valid = v_s4;
	assign out_data  = data_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	// stage 1: 450 - heading plus 90 turns, always positive
	assign u_nx = U_W'(18'(HEADING_OFS) - {{(18-HEADING_W){heading[HEADING_W-1]}}, heading});

	// stage 2: quotient by 360 through the reciprocal
	assign prod = (U_W+RECIP_W)'(u_s1) * (U_W+RECIP_W)'(RECIP_360);

	// stage 3: remainder, minus the first mount angle, quadrant split
	always_comb begin
		rem = u_s2 - U_W'(U_W'(qt_s2) * U_W'(DEG_FULL));
		a   = rem[ANGLE_W-1:0];
		if (a >= ANGLE_W'(MOUNT_OFS))
			x0 = a - ANGLE_W'(MOUNT_OFS);
		else
			x0 = a + ANGLE_W'(DEG_FULL - MOUNT_OFS);
		if (x0 >= ANGLE_W'(DEG_3Q)) begin
			quad_nx = 2'd3;
			base    = ANGLE_W'(DEG_3Q);
		end else if (x0 >= ANGLE_W'(DEG_HALF)) begin
			quad_nx = 2'd2;
			base    = ANGLE_W'(DEG_HALF);
		end else if (x0 >= ANGLE_W'(DEG_QUARTER)) begin
			quad_nx = 2'd1;
			base    = ANGLE_W'(DEG_QUARTER);
		end else begin
			quad_nx = 2'd0;
			base    = '0;
		end
	end

	// stage 4: sine and cosine magnitudes, per-wheel sign and selection
	always_comb begin
		s_r     = SINE_Q15[r_s3];
		s_c     = SINE_Q15[R_W'(DEG_QUARTER) - r_s3];
		cos_big = (s_c >= s_r);
		m       = cos_big ? s_c : s_r;
		lesser  = cos_big ? s_r : s_c;
		data_nx.num = (NUM_W'(lesser) << ONE_Q15_SHIFT) + NUM_W'(m >> 1);
		data_nx.den = DEN_W'(m);
		for (int i = 0; i < N_WHEELS; i++) begin
			qi = quad_s3 - 2'(i);
			// even quadrants take the cosine magnitude, odd ones the sine
			data_nx.side.big[i] = qi[0] ? !cos_big || (s_r == s_c) : cos_big;
			data_nx.side.neg[i] = (qi == 2'd1) || (qi == 2'd2);
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) u_s1 <= u_nx;
		if (adv2) begin
			u_s2  <= u_s1;
			qt_s2 <= prod[RECIP_SHIFT+QT_W-1:RECIP_SHIFT];
		end
		if (adv3) begin
			quad_s3 <= quad_nx;
			r_s3    <= R_W'(x0 - base);
		end
		if (adv4) data_s4 <= data_nx;
	end

endmodule

`default_nettype wire

FILE: rtl/owdm_div.sv
// ----------------------------------------------------------------------------
// owdm_div
// Pipelined restoring divider for the normalization, a fixed number of
// quotient bits resolved per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module owdm_div (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  owdm_pkg::div_in_t   in_data,
	output logic                out_valid,
	input  wire                 out_ready,
	output owdm_pkg::div_out_t  out_data
);
	import owdm_pkg::*;

	logic             vld_s  [DIV_STAGES];
	logic [NUM_W-1:0] rem_s  [DIV_STAGES];
	logic [QUO_W-1:0] quo_s  [DIV_STAGES];
	logic [DEN_W-1:0] den_s  [DIV_STAGES];
	side_t            side_s [DIV_STAGES];
	logic             adv    [DIV_STAGES+1];

	assign adv[DIV_STAGES] = out_ready;
	assign in_ready        = adv[0];
	assign out_valid       = vld_s[DIV_STAGES-1];
	assign out_data.quot   = quo_s[DIV_STAGES-1];
	assign out_data.side   = side_s[DIV_STAGES-1];

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
		logic             v_in;
		logic [NUM_W-1:0] rem_in, rem_nx;
		logic [QUO_W-1:0] quo_in, quo_nx;
		logic [DEN_W-1:0] den_in;
		side_t            side_in;

		if (j == 0) begin : g_first
			assign v_in    = in_valid;
			assign rem_in  = in_data.num;
			assign quo_in  = '0;
			assign den_in  = in_data.den;
			assign side_in = in_data.side;
		end else begin : g_next
			assign v_in    = vld_s[j-1];
			assign rem_in  = rem_s[j-1];
			assign quo_in  = quo_s[j-1];
			assign den_in  = den_s[j-1];
			assign side_in = side_s[j-1];
		end

		assign adv[j] = !vld_s[j] || adv[j+1];

		// compare and subtract for this stage's quotient bits, msb first
		always_comb begin
			rem_nx = rem_in;
			quo_nx = quo_in;
			for (int b = 0; b < DIV_STEP_BITS; b++) begin
				if (rem_nx >= (NUM_W'(den_in) << (QUO_W - 1 - j * DIV_STEP_BITS - b))) begin
					rem_nx = rem_nx - (NUM_W'(den_in) << (QUO_W - 1 - j * DIV_STEP_BITS - b));
					quo_nx[QUO_W - 1 - j * DIV_STEP_BITS - b] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[j] <= 1'b0;
			else if (adv[j])
				vld_s[j] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (adv[j]) begin
				rem_s[j]  <= rem_nx;
				quo_s[j]  <= quo_nx;
				den_s[j]  <= den_in;
				side_s[j] <= side_in;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/owdm_scale.sv
// ----------------------------------------------------------------------------
// owdm_scale
// Speed scaling by the squared gain, sign and reverse handling, and the
// rounded, saturated duty of each wheel in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module owdm_scale #(
	parameter int unsigned DUTY_BITS = 16
) (
	input  wire                                          clk,
	input  wire                                          arst_n,
	input  wire                                          in_valid,
	output logic                                         in_ready,
	input  owdm_pkg::div_out_t                           in_data,
	input  wire [owdm_pkg::GSQ_W-1:0]                    gain_sq,
	input  wire [owdm_pkg::N_WHEELS-1:0]                 rev,
	output logic                                         out_valid,
	input  wire                                          out_ready,
	output logic [owdm_pkg::N_WHEELS-1:0][DUTY_BITS-1:0] duty
);
	import owdm_pkg::*;

	localparam int SHIFT = 48 - DUTY_BITS;
	localparam int T_W   = 51;
	localparam int PR_W  = QUO_W + GSQ_W;

	logic v_s13, v_s14;
	logic adv13, adv14;

	logic [P_W-1:0]  p_small_s13, p_big_s13;
	side_t           side_s13;
	logic [N_WHEELS-1:0][DUTY_BITS-1:0] duty_s14;

	logic [PR_W-1:0] prod;
	logic [N_WHEELS-1:0][DUTY_BITS-1:0] duty_nx;
	logic [P_W-1:0]  p;
	logic            neg;
	logic [T_W-1:0]  t, tr, full;

	assign adv14     = !v_s14 || out_ready;
	assign adv13     = !v_s13 || adv14;
	assign in_ready  = adv13;
	assign out_valid = v_s14;
	assign duty      = duty_s14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
		end else begin
			if (adv13) v_s13 <= in_valid;
			if (adv14) v_s14 <= v_s13;
		end
	end

	// normalized magnitude times gain squared; the larger one is exactly one
	assign prod = PR_W'(in_data.quot) * PR_W'(gain_sq);

	// offset by one half, clamp at zero, round to the duty width, saturate
	always_comb begin
		p    = '0;
		neg  = 1'b0;
		t    = '0;
		tr   = '0;
		full = '0;
		for (int i = 0; i < N_WHEELS; i++) begin
			p   = side_s13.big[i] ? p_big_s13 : p_small_s13;
			neg = side_s13.neg[i] ^ rev[i];
			if (!neg)
				t = (T_W'(1) << 47) + T_W'(p);
			else if (T_W'(p) >= (T_W'(1) << 47))
				t = '0;
			else
				t = (T_W'(1) << 47) - T_W'(p);
			tr   = t + (T_W'(1) << (SHIFT - 1));
			full = tr >> SHIFT;
			if (|full[T_W-1:DUTY_BITS])
				duty_nx[i] = '1;
			else
				duty_nx[i] = full[DUTY_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv13) begin
			p_small_s13 <= prod[P_W-1:0];
			p_big_s13   <= P_W'(gain_sq) << ONE_Q15_SHIFT;
			side_s13    <= in_data.side;
		end
		if (adv14) duty_s14 <= duty_nx;
	end

endmodule

`default_nettype wire

FILE: tb/sv/owdm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owdm_checker
// Watches the heading, duty and configuration channels of the omni wheel
// duty mixer, keeps its own copy of gain and reverse mask, works out the four
// wheel duties of every accepted heading and compares each duty beat with the
// oldest outstanding prediction, wheel by wheel.
// ----------------------------------------------------------------------------

module owdm_checker #(
	parameter int unsigned DUTY_BITS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	owdm_cmd_if         cmd,
	owdm_duty_if        duty,
	owdm_cfg_if         cfg,
	output int unsigned fail_count,
	output int unsigned pending_count
);
	import owdm_pkg::*;

	typedef logic [N_WHEELS-1:0][DUTY_BITS-1:0] wheel_duties_t;

	// mixing constants
	localparam int HEADING_FLIP_DEG = 450;
	localparam int TURN_DEG         = 360;
	localparam int RIGHT_DEG        = 90;
	localparam int FIRST_MOUNT_DEG  = 45;
	localparam logic [GAIN_W-1:0]   GAIN_AT_RESET = GAIN_W'(13107);
	localparam logic [N_WHEELS-1:0] MASK_AT_RESET = N_WHEELS'(4);

	// fixed point: unit cosine in Q1.15, drive midpoint at 2^47
	localparam longint unsigned ONE_Q15    = 64'd32768;
	localparam longint unsigned MIDPOINT   = 64'd1 << 47;
	localparam int              ROUND_BITS = 48 - DUTY_BITS;
	localparam longint unsigned HALF_LSB   = 64'd1 << (ROUND_BITS - 1);
	localparam longint unsigned DUTY_MAX   = (64'd1 << DUTY_BITS) - 64'd1;

	// round(sin(k deg) * 32768), k = 0..90
	localparam logic [15:0] QUARTER_SINE [0:90] = '{
		16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
		16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
		16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
		16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
		16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
		16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
		16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
		16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
		16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
		16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
		16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
		16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
		16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
	};

	wheel_duties_t     expected_duties [$];
	logic [GAIN_W-1:0] gain_q;
	logic [N_WHEELS-1:0] rev_q;
	int unsigned       mismatch_total;

	// signed Q1.15 cosine of a whole angle 0..359 from the quarter wave
	function automatic int wheel_cosine(input int deg);
		int quad;
		int rem;
		quad = deg / RIGHT_DEG;
		rem  = deg % RIGHT_DEG;
		case (quad)
			0: return int'(QUARTER_SINE[RIGHT_DEG - rem]);
			1: return -int'(QUARTER_SINE[rem]);
			2: return -int'(QUARTER_SINE[RIGHT_DEG - rem]);
			default: return int'(QUARTER_SINE[rem]);
		endcase
	endfunction

	// heading to four normalized, gain-scaled, direction-corrected duties
	function automatic wheel_duties_t mix_duties(
		input logic signed [HEADING_W-1:0] hdg,
		input logic [GAIN_W-1:0]           gain,
		input logic [N_WHEELS-1:0]         rev
	);
		wheel_duties_t   res;
		int              course;
		int              rel;
		int              peak;
		int              cosv [N_WHEELS];
		longint unsigned peak_u;
		longint unsigned mag;
		longint unsigned norm;
		longint unsigned drive;
		longint unsigned level;
		longint unsigned dval;
		bit              flip;

		// exact integer angle, no wrap of the flipped heading
		course = (HEADING_FLIP_DEG - int'(hdg)) % TURN_DEG;
		if (course < 0)
			course += TURN_DEG;

		peak = 1;
		for (int w = 0; w < N_WHEELS; w++) begin
			rel = (course - FIRST_MOUNT_DEG - RIGHT_DEG * w) % TURN_DEG;
			if (rel < 0)
				rel += TURN_DEG;
			cosv[w] = wheel_cosine(rel);
			if (cosv[w] > peak)
				peak = cosv[w];
		end
		peak_u = 64'(peak);

		for (int w = 0; w < N_WHEELS; w++) begin
			flip = cosv[w] < 0;
			mag  = 64'(flip ? -cosv[w] : cosv[w]);
			// divide by the largest cosine, rounding half away from zero
			norm  = (mag * ONE_Q15 + peak_u / 2) / peak_u;
			drive = norm * gain * gain;
			if (rev[w])
				flip = !flip;
			if (flip)
				level = (drive > MIDPOINT) ? 64'd0 : MIDPOINT - drive;
			else
				level = MIDPOINT + drive;
			dval = (level + HALF_LSB) >> ROUND_BITS;
			if (dval > DUTY_MAX)
				dval = DUTY_MAX;
			res[w] = dval[DUTY_BITS-1:0];
		end
		return res;
	endfunction

	// follow register writes, queue predictions, compare duty beats
	always @(posedge clk or negedge arst_n) begin
		wheel_duties_t got;
		wheel_duties_t want;
		if (!arst_n) begin
			gain_q = GAIN_AT_RESET;
			rev_q  = MASK_AT_RESET;
			expected_duties.delete();
			mismatch_total = 0;
			fail_count    <= 0;
			pending_count <= 0;
		end else begin
			// register write beat; unknown indexes change nothing
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_SPEED_GAIN:   gain_q = cfg.data[GAIN_W-1:0];
					REG_REVERSE_MASK: rev_q  = cfg.data[N_WHEELS-1:0];
					default: ;
				endcase
			end

			// heading beat
			if (cmd.valid && cmd.ready)
				expected_duties.push_back(mix_duties(cmd.heading, gain_q, rev_q));

			// duty beat
			if (duty.valid && duty.ready) begin
				got = {duty.duty_wheel3, duty.duty_wheel2, duty.duty_wheel1, duty.duty_wheel0};
				if (expected_duties.size() == 0) begin
					mismatch_total++;
					$display("%0t unexpected duty beat: expected none, actual %0d %0d %0d %0d",
						$time, got[0], got[1], got[2], got[3]);
				end else begin
					want = expected_duties.pop_front();
					for (int w = 0; w < N_WHEELS; w++) begin
						if (got[w] !== want[w]) begin
							mismatch_total++;
							$display("%0t wheel %0d duty mismatch: expected %0d, actual %0d",
								$time, w, want[w], got[w]);
						end
					end
				end
			end

			fail_count    <= mismatch_total;
			pending_count <= expected_duties.size();
		end
	end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives headings and register writes into the omni wheel duty mixer with
// random gaps and output stalls, across several gain and reverse-mask
// settings, and reports the verdict of the checker at the end of the run.
// ----------------------------------------------------------------------------

module tb_top;
	import owdm_pkg::*;

	localparam int unsigned DUTY_BITS     = 16;
	localparam int          PHASES        = 8;
	localparam int          PHASE_BEATS   = 190;
	localparam int          HOLD_CYCLES   = 400;
	localparam int          SETTLE_CYCLES = 40;
	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int          MAX_GAIN      = 131071;
	localparam int          UNITY_GAIN    = 65536;
	localparam int          ALL_WHEELS    = 15;

	// indexes past the last register, written to show they are ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

	// heading extremes, cardinal and mount angles, alternating bit patterns
	localparam int DIRECTED_HEADINGS [25] = '{
		-32768, 32767, 0, -1, 1, 45, 90, 135, 180, 225, 270, 315, 359,
		360, 450, -450, 44, 46, 89, -90, 720, 21845, -21846, 32760, -32760
	};

	logic        clk;
	logic        arst_n;
	int unsigned fail_count;
	int unsigned pending_count;
	int unsigned cycle_count;
	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	bit          hold_arm;

	owdm_cmd_if                              cmd_ch ();
	owdm_duty_if #(.DUTY_BITS(DUTY_BITS))    duty_ch ();
	owdm_cfg_if                              cfg_ch ();

	omni_wheel_duty_mixer #(.DUTY_BITS(DUTY_BITS)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.duty   (duty_ch),
		.cfg    (cfg_ch)
	);

	owdm_checker #(.DUTY_BITS(DUTY_BITS)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd_ch),
		.duty          (duty_ch),
		.cfg           (cfg_ch),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// duty sink: random stalls plus one long hold-off once armed
	initial begin : duty_sink
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		duty_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				duty_ch.ready <= 1'b0;
				hold_left--;
			end else if (hold_arm && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				duty_ch.ready <= 1'b0;
			end else begin
				duty_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// one heading beat, with random idle cycles ahead of it
	task automatic send_heading(input logic signed [HEADING_W-1:0] hdg);
		while ($urandom_range(99) < tx_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.heading <= hdg;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
	endtask

	// one register write beat; the caller lowers valid after the last one
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
	endtask

	// load gain and mask, optionally poking the unused indexes too
	task automatic program_phase(input logic [GAIN_W-1:0] gain,
		input logic [N_WHEELS-1:0] mask, input bit spare_too);
		write_reg(REG_SPEED_GAIN, CFG_DATA_W'(gain));
		if (spare_too)
			write_reg(REG_SPARE_A, CFG_DATA_W'($urandom_range(MAX_GAIN)));
		// upper data bits are don't-care for the mask
		write_reg(REG_REVERSE_MASK, {(CFG_DATA_W - N_WHEELS)'($urandom), mask});
		if (spare_too)
			write_reg(REG_SPARE_B, CFG_DATA_W'($urandom_range(MAX_GAIN)));
		cfg_ch.valid <= 1'b0;
	endtask

	// stimulus and verdict
	initial begin : stimulus
		logic [GAIN_W-1:0]           gain;
		logic [N_WHEELS-1:0]         mask;
		logic signed [HEADING_W-1:0] hdg;
		int unsigned                 near;

		arst_n         = 1'b0;
		cmd_ch.valid   = 1'b0;
		cmd_ch.heading = '0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.index   = REG_SPEED_GAIN;
		cfg_ch.data    = '0;
		tx_idle_pct    = 14;
		rx_idle_pct    = 56;
		hold_arm       = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < PHASES; p++) begin
			// light sender gaps first, then heavy, then none
			if (p < 3) begin
				tx_idle_pct = 14;
				rx_idle_pct = 56;
			end else if (p < 6) begin
				tx_idle_pct = 56;
				rx_idle_pct = 14;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end

			if (p == 0) begin
				// reset settings, directed headings
				foreach (DIRECTED_HEADINGS[k])
					send_heading(HEADING_W'(DIRECTED_HEADINGS[k]));
			end else begin
				case (p)
					1: begin
						gain = GAIN_W'(UNITY_GAIN);
						mask = '0;
					end
					2: begin
						gain = '0;
						mask = N_WHEELS'(ALL_WHEELS);
					end
					3: begin
						gain = GAIN_W'(MAX_GAIN);
						mask = N_WHEELS'(10);
					end
					4: begin
						gain = GAIN_W'(1);
						mask = N_WHEELS'(5);
					end
					default: begin
						gain = GAIN_W'($urandom_range(MAX_GAIN));
						mask = N_WHEELS'($urandom_range(ALL_WHEELS));
					end
				endcase
				program_phase(gain, mask, p >= 3);
				// fill the pipe against a stalled output once
				if (p == 1)
					hold_arm = 1'b1;
			end

			for (int k = 0; k < PHASE_BEATS; k++) begin
				case ($urandom_range(3))
					0, 1: hdg = HEADING_W'($urandom_range(65535));
					2: hdg = HEADING_W'(int'($urandom_range(1440)) - 720);
					default: begin
						near = $urandom_range(15);
						if ($urandom_range(1))
							hdg = HEADING_W'(32767 - int'(near));
						else
							hdg = HEADING_W'(-32768 + int'(near));
					end
				endcase
				send_heading(hdg);
			end
			cmd_ch.valid <= 1'b0;

			// hold the sender until every duty beat is back
			@(posedge clk);
			while (pending_count != 0)
				@(posedge clk);
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/owdm_pkg.sv
rtl/owdm_if.sv
rtl/owdm_front.sv
rtl/owdm_div.sv
rtl/owdm_scale.sv
rtl/omni_wheel_duty_mixer.sv
tb/sv/owdm_checker.sv
tb/sv/tb_top.sv
